/* hdl/rsds_pkg.sv */
`timescale 1ns / 1ps

package rsds_pkg;

	// field widths
	localparam int CH_W    = 5;
	localparam int RAW_W   = 12;
	localparam int OUT_W   = 16;
	localparam int NCH_W   = 4;
	localparam int NM_W    = 9;
	localparam int EDGE_W  = 14;            // signed edge values, -511 .. 4606
	localparam int SPAN_W  = 13;            // raw offset and span on a mapped segment
	localparam int DY_W    = OUT_W + 1;     // output difference
	localparam int PROD_W  = SPAN_W + 1 + DY_W;
	localparam int Q_W     = 16;            // quotient never exceeds the output difference
	localparam int MAG_W   = SPAN_W + Q_W;  // dividend magnitude
	localparam int DIV_STAGES = Q_W / 2;    // two quotient bits per stage

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MIN         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MID         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_MARGIN    = 3'd4;

	localparam logic [NCH_W-1:0] RST_ACTIVE_CHANNELS = 4'd14;
	localparam logic [RAW_W-1:0] RST_RAW_MIN         = 12'd1000;
	localparam logic [RAW_W-1:0] RST_RAW_MAX         = 12'd2000;
	localparam logic [RAW_W-1:0] RST_RAW_MID         = 12'd1500;
	localparam logic [NM_W-1:0]  RST_NOISE_MARGIN    = 9'd10;

	// channels mapped over the whole inner span, no centre deadband
	localparam logic [CH_W-1:0] CH_FULL_A = 5'd2;
	localparam logic [CH_W-1:0] CH_FULL_B = 5'd4;
	localparam logic [CH_W-1:0] CH_FULL_C = 5'd5;

	typedef struct packed {
		logic signed [CH_W-1:0]  channel_index;
		logic        [RAW_W-1:0] raw_value;
		logic signed [OUT_W-1:0] out_min;
		logic signed [OUT_W-1:0] out_max;
	} sample_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] scaled_value;
		logic                    index_valid;
	} result_t;

	typedef struct packed {
		logic [NCH_W-1:0] active_channels;
		logic [RAW_W-1:0] raw_min;
		logic [RAW_W-1:0] raw_max;
		logic [RAW_W-1:0] raw_mid;
		logic [NM_W-1:0]  noise_margin;
	} cfg_t;

	// linear map job after classification
	typedef struct packed {
		logic                    ok;
		logic                    direct;
		logic signed [OUT_W-1:0] direct_val;
		logic signed [OUT_W-1:0] lo_out;
		logic        [SPAN_W-1:0] d;
		logic        [SPAN_W-1:0] span;
		logic signed [DY_W-1:0]  dy;
	} map_job_t;

	// what travels alongside the divider
	typedef struct packed {
		logic                    ok;
		logic                    direct;
		logic signed [OUT_W-1:0] direct_val;
		logic signed [OUT_W-1:0] lo_out;
		logic                    neg;
		logic                    zero_span;
	} side_t;

	// one restoring division step: {quotient bit, new remainder}
	function automatic logic [SPAN_W:0] div_step(input logic [SPAN_W-1:0] rem,
		input logic bit_in, input logic [SPAN_W-1:0] span);
		logic [SPAN_W:0] t;
		logic [SPAN_W:0] diff;
		t = {rem, bit_in};
		diff = t - {1'b0, span};
		if (t >= {1'b0, span}) begin
			div_step = {1'b1, diff[SPAN_W-1:0]};
		end else begin
			div_step = {1'b0, t[SPAN_W-1:0]};
		end
	endfunction

endpackage

/* hdl/rc_stick_deadband_scaler.sv */
`timescale 1ns / 1ps
// throughput: one item per cycle, busy is always low
// the divider is an 8-stage restoring divider, two quotient bits per stage
// results appear on done for one cycle and cannot be held off by the receiver
// arst_n clears the pipeline valid bits and loads the register reset values

module rc_stick_deadband_scaler import rsds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  sample_t               sample,
	output logic                  done,
	output result_t               result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_idx,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	// configuration registers; write them only while the pipeline is empty (not enforced here)
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_channels <= RST_ACTIVE_CHANNELS;
			cfg_q.raw_min         <= RST_RAW_MIN;
			cfg_q.raw_max         <= RST_RAW_MAX;
			cfg_q.raw_mid         <= RST_RAW_MID;
			cfg_q.noise_margin    <= RST_NOISE_MARGIN;
		end else if (wr_en) begin
			case (wr_idx)
				REG_ACTIVE_CHANNELS: cfg_q.active_channels <= wr_data[NCH_W-1:0];
				REG_RAW_MIN:         cfg_q.raw_min         <= wr_data[RAW_W-1:0];
				REG_RAW_MAX:         cfg_q.raw_max         <= wr_data[RAW_W-1:0];
				REG_RAW_MID:         cfg_q.raw_mid         <= wr_data[RAW_W-1:0];
				REG_NOISE_MARGIN:    cfg_q.noise_margin    <= wr_data[NM_W-1:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// fully pipelined, never stalls
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// stages 1-3: index check, segment choice, offsets
	logic     job_vld;
	map_job_t job;

	rsds_classify u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.sample  (sample),
		.cfg     (cfg_q),
		.job_vld (job_vld),
		.job     (job)
	);

	// stages 4-5: product of offset and output difference, then magnitude
	logic              div_vld;
	side_t             div_side;
	logic [MAG_W-1:0]  div_mag;
	logic [SPAN_W-1:0] div_span;

	rsds_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_vld  (job_vld),
		.job      (job),
		.div_vld  (div_vld),
		.div_side (div_side),
		.div_mag  (div_mag),
		.div_span (div_span)
	);

	// stages 6-13: truncating division by the segment span
	logic           quo_vld;
	side_t          quo_side;
	logic [Q_W-1:0] quo;

	rsds_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.div_vld  (div_vld),
		.div_side (div_side),
		.div_mag  (div_mag),
		.div_span (div_span),
		.quo_vld  (quo_vld),
		.quo_side (quo_side),
		.quo      (quo)
	);

	// stage 14: sign back, add segment base, pick the final value
	// quotient never exceeds the output difference, so the sum stays in range
	logic signed [DY_W-1:0]  q_signed;
	logic signed [DY_W-1:0]  mapped;
	logic signed [OUT_W-1:0] value_c;

	always_comb begin
		q_signed = quo_side.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		mapped   = {quo_side.lo_out[OUT_W-1], quo_side.lo_out} + q_signed;
		if (!quo_side.ok) begin
			value_c = '0;
		end else if (quo_side.direct) begin
			value_c = quo_side.direct_val;
		end else if (quo_side.zero_span) begin
			// degenerate segment gives its lower output
			value_c = quo_side.lo_out;
		end else begin
			value_c = mapped[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= quo_vld;
		end
	end

	always_ff @(posedge clk) begin
		result.scaled_value <= value_c;
		result.index_valid  <= quo_side.ok;
	end

	// every accepted item comes out on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##14 done)
		else $error("item did not complete after pipeline latency");

	// no result without a matching accepted item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 14))
		else $error("result without a matching item");

	// a rejected channel index always reads as zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.index_valid) |-> (result.scaled_value == '0))
		else $error("invalid index gave a nonzero value");

endmodule

/* hdl/rsds_classify.sv */
`timescale 1ns / 1ps

module rsds_classify import rsds_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_vld,
	input  sample_t  sample,
	input  cfg_t     cfg,
	output logic     job_vld,
	output map_job_t job
);

	// stage 1: edges, midpoint, index check
	logic                     vld_s1;
	logic                     ok_s1;
	logic                     full_s1;
	logic        [RAW_W-1:0]  x_s1;
	logic signed [OUT_W-1:0]  omin_s1;
	logic signed [OUT_W-1:0]  omax_s1;
	logic signed [OUT_W-1:0]  mid_s1;
	logic signed [EDGE_W-1:0] lo_edge_s1;
	logic signed [EDGE_W-1:0] hi_edge_s1;
	logic signed [EDGE_W-1:0] mlo_s1;
	logic signed [EDGE_W-1:0] mhi_s1;

	logic signed [OUT_W:0]    mid_sum;
	logic signed [OUT_W:0]    mid_adj;
	logic signed [EDGE_W-1:0] nm_ext;
	logic signed [EDGE_W-1:0] rmin_ext;
	logic signed [EDGE_W-1:0] rmax_ext;
	logic signed [EDGE_W-1:0] rmid_ext;

	always_comb begin
		nm_ext   = $signed({{(EDGE_W-NM_W){1'b0}}, cfg.noise_margin});
		rmin_ext = $signed({{(EDGE_W-RAW_W){1'b0}}, cfg.raw_min});
		rmax_ext = $signed({{(EDGE_W-RAW_W){1'b0}}, cfg.raw_max});
		rmid_ext = $signed({{(EDGE_W-RAW_W){1'b0}}, cfg.raw_mid});
		mid_sum  = {sample.out_min[OUT_W-1], sample.out_min}
			+ {sample.out_max[OUT_W-1], sample.out_max};
		// truncate toward zero
		mid_adj  = mid_sum + {{OUT_W{1'b0}}, mid_sum[OUT_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1      <= !sample.channel_index[CH_W-1]
			&& (sample.channel_index[NCH_W-1:0] < cfg.active_channels);
		full_s1    <= (sample.channel_index == CH_FULL_A)
			|| (sample.channel_index == CH_FULL_B)
			|| (sample.channel_index == CH_FULL_C);
		x_s1       <= sample.raw_value;
		omin_s1    <= sample.out_min;
		omax_s1    <= sample.out_max;
		mid_s1     <= mid_adj[OUT_W:1];
		lo_edge_s1 <= rmin_ext + nm_ext;
		hi_edge_s1 <= rmax_ext - nm_ext;
		mlo_s1     <= rmid_ext - nm_ext;
		mhi_s1     <= rmid_ext + nm_ext;
	end

	// stage 2: pick the segment
	logic                     vld_s2;
	logic                     ok_s2;
	logic                     direct_s2;
	logic signed [OUT_W-1:0]  dval_s2;
	logic        [RAW_W-1:0]  x_s2;
	logic signed [EDGE_W-1:0] lo_in_s2;
	logic signed [EDGE_W-1:0] hi_in_s2;
	logic signed [OUT_W-1:0]  lo_out_s2;
	logic signed [OUT_W-1:0]  hi_out_s2;

	logic signed [EDGE_W-1:0] x_ext;
	logic                     direct_c;
	logic signed [OUT_W-1:0]  dval_c;
	logic signed [EDGE_W-1:0] lo_in_c;
	logic signed [EDGE_W-1:0] hi_in_c;
	logic signed [OUT_W-1:0]  lo_out_c;
	logic signed [OUT_W-1:0]  hi_out_c;

	always_comb begin
		x_ext    = $signed({{(EDGE_W-RAW_W){1'b0}}, x_s1});
		direct_c = 1'b0;
		dval_c   = mid_s1;
		lo_in_c  = lo_edge_s1;
		hi_in_c  = hi_edge_s1;
		lo_out_c = omin_s1;
		hi_out_c = omax_s1;
		if (x_ext < lo_edge_s1) begin
			direct_c = 1'b1;
			dval_c   = omin_s1;
		end else if (x_ext > hi_edge_s1) begin
			direct_c = 1'b1;
			dval_c   = omax_s1;
		end else if (full_s1) begin
			direct_c = 1'b0;
		end else if (x_ext < mlo_s1) begin
			hi_in_c  = mlo_s1;
			hi_out_c = mid_s1;
		end else if (x_ext > mhi_s1) begin
			lo_in_c  = mhi_s1;
			lo_out_c = mid_s1;
		end else begin
			direct_c = 1'b1;
			dval_c   = mid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2     <= ok_s1;
		direct_s2 <= direct_c;
		dval_s2   <= dval_c;
		x_s2      <= x_s1;
		lo_in_s2  <= lo_in_c;
		hi_in_s2  <= hi_in_c;
		lo_out_s2 <= lo_out_c;
		hi_out_s2 <= hi_out_c;
	end

	// stage 3: offsets and differences
	logic signed [EDGE_W-1:0] d_full;
	logic signed [EDGE_W-1:0] span_full;

	always_comb begin
		d_full    = $signed({{(EDGE_W-RAW_W){1'b0}}, x_s2}) - lo_in_s2;
		span_full = hi_in_s2 - lo_in_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld <= 1'b0;
		end else begin
			job_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		job.ok         <= ok_s2;
		job.direct     <= direct_s2;
		job.direct_val <= dval_s2;
		job.lo_out     <= lo_out_s2;
		job.d          <= d_full[SPAN_W-1:0];
		job.span       <= span_full[SPAN_W-1:0];
		job.dy         <= {hi_out_s2[OUT_W-1], hi_out_s2} - {lo_out_s2[OUT_W-1], lo_out_s2};
	end

endmodule

/* hdl/rsds_mult.sv */
`timescale 1ns / 1ps

module rsds_mult import rsds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_vld,
	input  map_job_t          job,
	output logic              div_vld,
	output side_t             div_side,
	output logic [MAG_W-1:0]  div_mag,
	output logic [SPAN_W-1:0] div_span
);

	// stage 4: product
	logic                     vld_s4;
	map_job_t                 job_s4;
	logic signed [PROD_W-1:0] prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= job_vld;
		end
	end

	always_ff @(posedge clk) begin
		job_s4  <= job;
		prod_s4 <= $signed({1'b0, job.d}) * job.dy;
	end

	// stage 5: sign and magnitude
	logic signed [PROD_W-1:0] prod_abs;

	assign prod_abs = prod_s4[PROD_W-1] ? -prod_s4 : prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld <= 1'b0;
		end else begin
			div_vld <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		div_side.ok         <= job_s4.ok;
		div_side.direct     <= job_s4.direct;
		div_side.direct_val <= job_s4.direct_val;
		div_side.lo_out     <= job_s4.lo_out;
		div_side.neg        <= prod_s4[PROD_W-1];
		div_side.zero_span  <= (job_s4.span == '0);
		div_mag             <= prod_abs[MAG_W-1:0];
		div_span            <= job_s4.span;
	end

endmodule

/* hdl/rsds_divider.sv */
`timescale 1ns / 1ps

module rsds_divider import rsds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              div_vld,
	input  side_t             div_side,
	input  logic [MAG_W-1:0]  div_mag,
	input  logic [SPAN_W-1:0] div_span,
	output logic              quo_vld,
	output side_t             quo_side,
	output logic [Q_W-1:0]    quo
);

	// one register stage per two quotient bits
	logic              vld_s  [DIV_STAGES];
	side_t             side_s [DIV_STAGES];
	logic [SPAN_W-1:0] rem_s  [DIV_STAGES];
	logic [SPAN_W-1:0] span_s [DIV_STAGES];
	logic [Q_W-1:0]    bits_s [DIV_STAGES];
	logic [Q_W-1:0]    quot_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic              vld_in;
		side_t             side_in;
		logic [SPAN_W-1:0] rem_in;
		logic [SPAN_W-1:0] span_in;
		logic [Q_W-1:0]    bits_in;
		logic [Q_W-1:0]    quot_in;
		logic [SPAN_W:0]   step_a;
		logic [SPAN_W:0]   step_b;

		if (k == 0) begin : g_first
			// high part of the dividend is below the divisor, so it seeds the remainder
			assign vld_in  = div_vld;
			assign side_in = div_side;
			assign rem_in  = div_mag[MAG_W-1:Q_W];
			assign span_in = div_span;
			assign bits_in = div_mag[Q_W-1:0];
			assign quot_in = '0;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign side_in = side_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign span_in = span_s[k-1];
			assign bits_in = bits_s[k-1];
			assign quot_in = quot_s[k-1];
		end

		assign step_a = div_step(rem_in, bits_in[Q_W-1], span_in);
		assign step_b = div_step(step_a[SPAN_W-1:0], bits_in[Q_W-2], span_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= side_in;
			rem_s[k]  <= step_b[SPAN_W-1:0];
			span_s[k] <= span_in;
			bits_s[k] <= {bits_in[Q_W-3:0], 2'b00};
			quot_s[k] <= {quot_in[Q_W-3:0], step_a[SPAN_W], step_b[SPAN_W]};
		end
	end

	assign quo_vld  = vld_s[DIV_STAGES-1];
	assign quo_side = side_s[DIV_STAGES-1];
	assign quo      = quot_s[DIV_STAGES-1];

	// remainder stays below a nonzero divisor on a real mapping
	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[DIV_STAGES-1] && side_s[DIV_STAGES-1].ok && !side_s[DIV_STAGES-1].direct
			&& !side_s[DIV_STAGES-1].zero_span)
		|-> (rem_s[DIV_STAGES-1] < span_s[DIV_STAGES-1]))
		else $error("divider remainder not below divisor");

endmodule
